// ===== rtl/core/dsss_pkg.sv =====
// Package for the dual stack shared store: action, status and command types.
// Used by dsss_front, dsss_queue, dsss_back and dual_stack_shared_store.
`default_nettype none

package dsss_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ACT_PUSH_A = 3'd0,
        ACT_PUSH_B = 3'd1,
        ACT_POP_A  = 3'd2,
        ACT_POP_B  = 3'd3,
        ACT_LIST_A = 3'd4,
        ACT_LIST_B = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_LIST = 2'd2
    } t_kind;

    // side: 0 selects stack A (bottom), 1 selects stack B (top)
    typedef struct packed {
        t_kind                     kind;
        logic                      side;
        logic signed [DATA_W-1:0]  value;
    } t_cmd;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_OUT  = 1'b1
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/dual_stack_shared_store.sv =====
// Dual stack shared store: two stacks in one store, A from the bottom, B from the top.
// Top level; instantiates dsss_front, dsss_queue and dsss_back, uses dsss_pkg.
//
// Input channel: i_valid / o_stall carry i_action and i_value. A transfer
// happens on a rising edge with i_valid high and o_stall low. Unused action
// codes are taken and dropped without a result.
// Output channel: o_valid / i_stall carry o_data, o_status and o_last; one
// transfer per result, o_last marks the final result of an input item.
// Commands pass through a two-entry queue, so input transfers continue while
// a result waits on i_stall; o_stall rises only when the queue is full.
// Push and pop: the back end takes the command and uses the store port (write,
// or registered read) in its idle state, then presents the result in its
// output state, so it takes no new command before the result is out.
// List: the first entry is read when the command is taken, then one result
// per cycle while not stalled, each from its own read of the single-port store.
// Reset clears both stack counts, the queue and the sequencer; store
// contents are not cleared. While i_stall is high the result holds unchanged.
`default_nettype none

module dual_stack_shared_store #(
    parameter int DEPTH = dsss_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [2:0]                          i_action,
    input  wire logic signed [dsss_pkg::DATA_W-1:0]  i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [dsss_pkg::DATA_W-1:0]       o_data,
    output logic [1:0]                               o_status,
    output logic                                     o_last
);

    dsss_pkg::t_cmd  w_front_cmd;
    dsss_pkg::t_cmd  w_back_cmd;
    logic            w_q_push;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_q_pop;

    dsss_front u_front (
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_value  (i_value),
        .i_q_full (w_q_full),
        .o_stall  (o_stall),
        .o_push   (w_q_push),
        .o_cmd    (w_front_cmd)
    );

    dsss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_back_cmd),
        .i_pop   (w_q_pop)
    );

    dsss_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_back_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dsss_front.sv =====
// Front end: accepts input transfers and turns each action into a command.
// Depends on dsss_pkg; feeds dsss_queue.
`default_nettype none

module dsss_front (
    input  wire logic                                i_valid,
    input  wire logic [2:0]                          i_action,
    input  wire logic signed [dsss_pkg::DATA_W-1:0]  i_value,
    input  wire logic                                i_q_full,
    output logic                                     o_stall,
    output logic                                     o_push,
    output dsss_pkg::t_cmd                           o_cmd
);

    logic w_known;

    always_comb begin
        w_known      = 1'b1;
        o_cmd.value  = i_value;
        o_cmd.kind   = dsss_pkg::CMD_PUSH;
        o_cmd.side   = 1'b0;
        unique case (dsss_pkg::t_action'(i_action))
            dsss_pkg::ACT_PUSH_A: begin
                o_cmd.kind = dsss_pkg::CMD_PUSH;
            end
            dsss_pkg::ACT_PUSH_B: begin
                o_cmd.kind = dsss_pkg::CMD_PUSH;
                o_cmd.side = 1'b1;
            end
            dsss_pkg::ACT_POP_A: begin
                o_cmd.kind = dsss_pkg::CMD_POP;
            end
            dsss_pkg::ACT_POP_B: begin
                o_cmd.kind = dsss_pkg::CMD_POP;
                o_cmd.side = 1'b1;
            end
            dsss_pkg::ACT_LIST_A: begin
                o_cmd.kind = dsss_pkg::CMD_LIST;
            end
            dsss_pkg::ACT_LIST_B: begin
                o_cmd.kind = dsss_pkg::CMD_LIST;
                o_cmd.side = 1'b1;
            end
            default: begin
                w_known = 1'b0;   // unused codes are taken and dropped
            end
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && w_known;

endmodule

`default_nettype wire

// ===== rtl/core/dsss_queue.sv =====
// Short command queue between front and back end.
// Depends on dsss_pkg.
`default_nettype none

module dsss_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire dsss_pkg::t_cmd  i_cmd,
    output logic                 o_full,
    output logic                 o_valid,
    output dsss_pkg::t_cmd       o_cmd,
    input  wire logic            i_pop
);

    localparam int QD    = dsss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int CNT_W = $clog2(QD + 1);

    dsss_pkg::t_cmd    r_entry [QD];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_pop;

    assign o_full  = (r_count == CNT_W'(QD));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rptr];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr = (r_wptr == PTR_W'(QD - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == PTR_W'(QD - 1)) ? '0 : r_rptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (w_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dsss_back.sv =====
// Back end: stack counters, shared single-port store and result sequencer.
// Depends on dsss_pkg; takes commands from dsss_queue.
`default_nettype none

module dsss_back #(
    parameter int DEPTH = dsss_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cmd_valid,
    input  wire dsss_pkg::t_cmd                      i_cmd,
    output logic                                     o_cmd_pop,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [dsss_pkg::DATA_W-1:0]       o_data,
    output logic [1:0]                               o_status,
    output logic                                     o_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dsss_pkg::t_back_state  r_state, n_state;

    logic [dsss_pkg::DATA_W-1:0]  r_mem [DEPTH];
    logic [dsss_pkg::DATA_W-1:0]  r_rdata;

    logic [CNT_W-1:0]   r_cnt_a, r_cnt_b;
    logic [IDX_W-1:0]   r_ptr;
    logic               r_side;
    logic               r_list;
    logic               r_use_mem;
    dsss_pkg::t_status  r_status;

    logic               w_take;
    logic               w_done;
    logic               w_full;
    logic               w_empty;
    logic               w_list_end;
    logic [IDX_W-1:0]   w_ptr_next;
    logic [IDX_W-1:0]   w_top;
    logic [IDX_W-1:0]   w_push_addr;
    logic               w_wr_en, w_rd_en;
    logic [IDX_W-1:0]   w_wr_addr, w_rd_addr;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsss_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = dsss_pkg::BK_OUT;
                end
            end
            dsss_pkg::BK_OUT: begin
                if (!i_stall && (!r_list || w_list_end)) begin
                    n_state = dsss_pkg::BK_IDLE;
                end
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        o_valid   = 1'b0;
        unique case (r_state)
            dsss_pkg::BK_IDLE: o_cmd_pop = i_cmd_valid;
            dsss_pkg::BK_OUT:  o_valid   = 1'b1;
        endcase
    end

    assign w_take = o_cmd_pop;
    assign w_done = o_valid && !i_stall;

    always_comb begin
        w_full      = ({1'b0, r_cnt_a} + {1'b0, r_cnt_b}) == (CNT_W + 1)'(DEPTH);
        w_empty     = i_cmd.side ? (r_cnt_b == '0) : (r_cnt_a == '0);
        w_top       = i_cmd.side ? IDX_W'(CNT_W'(DEPTH) - r_cnt_b)
                                 : IDX_W'(r_cnt_a - 1'b1);
        w_push_addr = i_cmd.side ? IDX_W'(CNT_W'(DEPTH) - r_cnt_b - 1'b1)
                                 : IDX_W'(r_cnt_a);
        w_list_end  = r_side ? (r_ptr == IDX_W'(DEPTH - 1)) : (r_ptr == '0);
        w_ptr_next  = r_side ? r_ptr + 1'b1 : r_ptr - 1'b1;
    end

    // store port control
    always_comb begin
        w_wr_en   = 1'b0;
        w_rd_en   = 1'b0;
        w_wr_addr = w_push_addr;
        w_rd_addr = w_top;
        if (w_take) begin
            unique case (i_cmd.kind)
                dsss_pkg::CMD_PUSH: w_wr_en = !w_full;
                dsss_pkg::CMD_POP:  w_rd_en = !w_empty;
                dsss_pkg::CMD_LIST: w_rd_en = !w_empty;
                default:            w_rd_en = 1'b0;
            endcase
        end else if (w_done && r_list && !w_list_end) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_ptr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_cmd.value;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsss_pkg::BK_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_list  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_side    <= i_cmd.side;
                r_ptr     <= w_top;
                r_list    <= 1'b0;
                r_use_mem <= 1'b0;
                unique case (i_cmd.kind)
                    dsss_pkg::CMD_PUSH: begin
                        if (w_full) begin
                            r_status <= dsss_pkg::ST_OVERFLOW;
                        end else begin
                            r_status <= dsss_pkg::ST_OK;
                            if (i_cmd.side) begin
                                r_cnt_b <= r_cnt_b + 1'b1;
                            end else begin
                                r_cnt_a <= r_cnt_a + 1'b1;
                            end
                        end
                    end
                    dsss_pkg::CMD_POP: begin
                        if (w_empty) begin
                            r_status <= dsss_pkg::ST_UNDERFLOW;
                        end else begin
                            r_status  <= dsss_pkg::ST_OK;
                            r_use_mem <= 1'b1;
                            if (i_cmd.side) begin
                                r_cnt_b <= r_cnt_b - 1'b1;
                            end else begin
                                r_cnt_a <= r_cnt_a - 1'b1;
                            end
                        end
                    end
                    dsss_pkg::CMD_LIST: begin
                        if (w_empty) begin
                            r_status <= dsss_pkg::ST_EMPTY;
                        end else begin
                            r_status  <= dsss_pkg::ST_OK;
                            r_use_mem <= 1'b1;
                            r_list    <= 1'b1;
                        end
                    end
                    default: begin
                        r_status <= dsss_pkg::ST_OK;
                    end
                endcase
            end else if (w_done && r_list && !w_list_end) begin
                r_ptr <= w_ptr_next;
            end
        end
    end

    assign o_data   = r_use_mem ? $signed(r_rdata) : '0;
    assign o_status = r_status;
    assign o_last   = r_list ? w_list_end : 1'b1;

endmodule

`default_nettype wire

// ===== tb/sv/dual_stack_shared_store_test.sv =====
// Self-checking testbench for dual_stack_shared_store: directed table, then random traffic.
// Depends on dsss_pkg and the dual_stack_shared_store RTL; predicts every result in-line.
// Sender bursts and receiver stall patterns are random; results are checked field by field.
`default_nettype none

module dual_stack_shared_store_test;

    localparam int STORE_DEPTH    = dsss_pkg::DEPTH_DEF;
    localparam int DW             = dsss_pkg::DATA_W;
    localparam int RANDOM_ITEMS   = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 24;

    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;
    localparam int MODE_LIST  = 3;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    typedef struct {
        logic signed [DW-1:0]  data;
        dsss_pkg::t_status     status;
        logic                  last;
    } t_result;

    typedef struct {
        logic [2:0]            act;
        logic signed [DW-1:0]  val;
        int                    reps;
        bit                    typed;
        dsss_pkg::t_status     st;
        logic signed [DW-1:0]  dat;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [2:0]            i_action;
    logic signed [DW-1:0]  i_value;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [DW-1:0]  o_data;
    logic [1:0]            o_status;
    logic                  o_last;

    dual_stack_shared_store #(
        .DEPTH(STORE_DEPTH)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data),
        .o_status (o_status),
        .o_last   (o_last)
    );

    // predicted stack image
    logic signed [DW-1:0] store_img [STORE_DEPTH];
    int unsigned          depth_a;
    int unsigned          depth_b;

    t_result expected_results[$];
    t_result exp_res;

    int error_count;
    int results_checked;
    int n_push, n_pop, n_list, n_overflow, n_underflow, n_empty_list, n_ignored;
    int idle_cycles;

    t_stim_row dir_rows [0:15] = '{
        '{dsss_pkg::ACT_POP_A,  32'sd0,         1, 1'b1, dsss_pkg::ST_UNDERFLOW, 32'sd0},
        '{dsss_pkg::ACT_POP_B,  32'sd0,         1, 1'b1, dsss_pkg::ST_UNDERFLOW, 32'sd0},
        '{dsss_pkg::ACT_LIST_A, 32'sd0,         1, 1'b1, dsss_pkg::ST_EMPTY,     32'sd0},
        '{dsss_pkg::ACT_LIST_B, 32'sd0,         1, 1'b1, dsss_pkg::ST_EMPTY,     32'sd0},
        '{ACT_UNUSED_6,         32'sh1234_5678, 1, 1'b0, dsss_pkg::ST_OK,        32'sd0},
        '{ACT_UNUSED_7,         32'shedcb_a987, 1, 1'b0, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_A, 32'sh7fff_ffff, 1, 1'b1, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_B, 32'sh8000_0000, 1, 1'b1, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_A, 32'shffff_ffff, 1, 1'b1, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_B, 32'sd0,         1, 1'b1, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_A, 32'sh0f0f_0f0f, 6, 1'b0, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_B, 32'shf0f0_f0f0, 6, 1'b0, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_PUSH_A, 32'sh5555_5555, 1, 1'b1, dsss_pkg::ST_OVERFLOW,  32'sd0},
        '{dsss_pkg::ACT_PUSH_B, 32'shaaaa_aaaa, 1, 1'b1, dsss_pkg::ST_OVERFLOW,  32'sd0},
        '{dsss_pkg::ACT_LIST_A, 32'sd0,         1, 1'b0, dsss_pkg::ST_OK,        32'sd0},
        '{dsss_pkg::ACT_LIST_B, 32'sd0,         1, 1'b0, dsss_pkg::ST_OK,        32'sd0}
    };

    int         row_idx;
    int         rep_idx;
    int         sent;
    int         burst_len;
    int         burst_num;
    int         gap_len;
    int         traffic_mode;
    bit         paused;
    logic [2:0] next_act;
    logic signed [DW-1:0] next_val;

    int stall_mode;
    int stall_len;
    int stall_phase;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void add_expected(input logic signed [DW-1:0] data,
                                         input dsss_pkg::t_status status, input logic last);
        t_result r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_stack_op(input logic [2:0] act,
                                             input logic signed [DW-1:0] val);
        bit          full;
        int unsigned idx;
        full = (depth_a + depth_b) >= STORE_DEPTH;
        case (act)
            dsss_pkg::ACT_PUSH_A, dsss_pkg::ACT_PUSH_B: begin
                n_push++;
                if (full) begin
                    n_overflow++;
                    add_expected('0, dsss_pkg::ST_OVERFLOW, 1'b1);
                end else begin
                    if (act == dsss_pkg::ACT_PUSH_A) begin
                        store_img[depth_a] = val;
                        depth_a++;
                    end else begin
                        depth_b++;
                        store_img[STORE_DEPTH - depth_b] = val;
                    end
                    add_expected('0, dsss_pkg::ST_OK, 1'b1);
                end
            end
            dsss_pkg::ACT_POP_A: begin
                n_pop++;
                if (depth_a == 0) begin
                    n_underflow++;
                    add_expected('0, dsss_pkg::ST_UNDERFLOW, 1'b1);
                end else begin
                    depth_a--;
                    add_expected(store_img[depth_a], dsss_pkg::ST_OK, 1'b1);
                end
            end
            dsss_pkg::ACT_POP_B: begin
                n_pop++;
                if (depth_b == 0) begin
                    n_underflow++;
                    add_expected('0, dsss_pkg::ST_UNDERFLOW, 1'b1);
                end else begin
                    idx = STORE_DEPTH - depth_b;
                    depth_b--;
                    add_expected(store_img[idx], dsss_pkg::ST_OK, 1'b1);
                end
            end
            dsss_pkg::ACT_LIST_A: begin
                n_list++;
                if (depth_a == 0) begin
                    n_empty_list++;
                    add_expected('0, dsss_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (idx = depth_a; idx > 0; idx--)
                        add_expected(store_img[idx - 1], dsss_pkg::ST_OK, idx == 1);
                end
            end
            dsss_pkg::ACT_LIST_B: begin
                n_list++;
                if (depth_b == 0) begin
                    n_empty_list++;
                    add_expected('0, dsss_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (idx = STORE_DEPTH - depth_b; idx < STORE_DEPTH; idx++)
                        add_expected(store_img[idx], dsss_pkg::ST_OK,
                                     idx == STORE_DEPTH - 1);
                end
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic logic [2:0] pick_action(input int mode);
        int r;
        int push_pct;
        int pop_pct;
        bit side;
        r = $urandom_range(0, 99);
        side = $urandom_range(0, 1);
        if (r < 4)
            return (r < 2) ? ACT_UNUSED_6 : ACT_UNUSED_7;
        case (mode)
            MODE_FILL:  begin push_pct = 75; pop_pct = 15; end
            MODE_DRAIN: begin push_pct = 15; pop_pct = 75; end
            MODE_MIXED: begin push_pct = 40; pop_pct = 40; end
            default:    begin push_pct = 35; pop_pct = 30; end
        endcase
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return side ? dsss_pkg::ACT_PUSH_B : dsss_pkg::ACT_PUSH_A;
        else if (r < push_pct + pop_pct)
            return side ? dsss_pkg::ACT_POP_B : dsss_pkg::ACT_POP_A;
        else
            return side ? dsss_pkg::ACT_LIST_B : dsss_pkg::ACT_LIST_A;
    endfunction

    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // holds the transfer until it is taken
    task automatic send_item(input logic [2:0] act, input logic signed [DW-1:0] val);
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_stack_op(act, val);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid  <= 1'b0;
            i_action <= $urandom;
            i_value  <= $urandom;
        end
    endtask

    // receiver stall pattern
    initial begin
        i_stall = 1'b0;
        stall_phase = 0;
        forever begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_len  = $urandom_range(8, 60);
            repeat (stall_len) begin
                @(negedge i_clk);
                stall_phase++;
                case (stall_mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 2) != 0);
                    default:     i_stall <= (stall_phase % 7) < 4;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: data %h status %0d last %0d",
                         $time, o_data, o_status, o_last);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                results_checked++;
                if (o_data !== exp_res.data) begin
                    $display("%0t: data mismatch: expected %h, actual %h",
                             $time, exp_res.data, o_data);
                    error_count++;
                end
                if (o_status !== exp_res.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, o_status);
                    error_count++;
                end
                if (o_last !== exp_res.last) begin
                    $display("%0t: last mismatch: expected %0d, actual %0d",
                             $time, exp_res.last, o_last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, expected_results.size());
        $display("dual_stack_shared_store verification failed");
        $finish;
    end

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_action = '0;
        i_value  = '0;
        depth_a  = 0;
        depth_b  = 0;
        error_count = 0;
        results_checked = 0;
        n_push = 0; n_pop = 0; n_list = 0;
        n_overflow = 0; n_underflow = 0; n_empty_list = 0; n_ignored = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row_idx = 0; row_idx < $size(dir_rows); row_idx++) begin
            for (rep_idx = 0; rep_idx < dir_rows[row_idx].reps; rep_idx++) begin
                send_item(dir_rows[row_idx].act, dir_rows[row_idx].val ^ rep_idx);
                if (dir_rows[row_idx].typed) begin
                    // a typed row yields exactly one result
                    void'(expected_results.pop_back());
                    add_expected(dir_rows[row_idx].dat, dir_rows[row_idx].st, 1'b1);
                end
            end
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 4));
        end

        sent = 0;
        burst_num = 0;
        paused = 1'b0;
        traffic_mode = MODE_DRAIN;
        while (sent < RANDOM_ITEMS) begin
            if (burst_num % 4 == 0)
                traffic_mode = $urandom_range(MODE_FILL, MODE_LIST);
            burst_num++;
            burst_len = $urandom_range(1, 12);
            repeat (burst_len) begin
                next_act = pick_action(traffic_mode);
                next_val = pick_value();
                send_item(next_act, next_val);
                if (next_act <= dsss_pkg::ACT_LIST_B)
                    sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                // let the result side run dry before going on
                paused = 1'b1;
                idle_sender(1);
                while (expected_results.size() != 0) @(negedge i_clk);
            end else begin
                gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                idle_sender(gap_len);
            end
        end

        idle_sender(1);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d pushes (%0d overflow), %0d pops (%0d underflow), %0d lists",
                 n_push, n_overflow, n_pop, n_underflow, n_list);
        $display("  (%0d empty), %0d ignored codes; %0d results compared, %0d errors",
                 n_empty_list, n_ignored, results_checked, error_count);
        if (error_count == 0) begin
            $display("dual_stack_shared_store verification clean");
        end else begin
            $display("dual_stack_shared_store verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
